[src/lio_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lio_pkg;

	localparam int unsigned MaxLines = 1024;
	localparam int unsigned AddrW    = $clog2(MaxLines);
	localparam int unsigned CntW     = AddrW + 1;
	localparam int unsigned OffW     = 20;
	localparam int unsigned PosW     = OffW + 1;
	localparam int unsigned MaxBytes = 2 ** OffW;

	localparam logic [7:0] ChLf = 8'h0A;
	localparam logic [7:0] ChCr = 8'h0D;

	typedef enum logic [1:0] {
		MODE_BYTE   = 2'd0,
		MODE_OFFSET = 2'd1,
		MODE_LINE   = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef struct packed {
		logic [PosW-1:0] a;
		logic [PosW-1:0] b;
	} sub_req_t;

	typedef struct packed {
		logic [PosW-1:0] diff;
		logic            lt;
	} sub_rsp_t;

endpackage

`default_nettype wire

[src/lio_sub.sv]
`timescale 1ns / 1ps
`default_nettype none

// shared subtract / compare: a - b and a < b
module lio_sub
	import lio_pkg::*;
(
	input  sub_req_t req,
	output sub_rsp_t rsp
);

	logic [PosW:0] wide;

	always_comb begin
		wide     = {1'b0, req.a} - {1'b0, req.b};
		rsp.diff = wide[PosW-1:0];
		rsp.lt   = wide[PosW];
	end

endmodule

`default_nettype wire

[src/line_index_offset_lookup.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel  Handshake             Payload
// in       in_valid / in_ready   mode, byte_value, query_offset, query_line
// out      out_valid / out_ready found, line_number, column_number, line_start,
//                                line_len, index_overflow
//
// Byte and clear transfers give no result.
// Offset query: a binary search of at most 11 steps at 1024 lines;
// each step is a line-start RAM read then one pass through the shared subtractor.
// Line query: two RAM reads then the length subtract; an out-of-range line skips them.
// Asynchronous reset; entry zero of the line table is supplied by logic, no clearing pass.
// A result waiting on out_ready holds the sequencer; in_ready is low while busy.
module line_index_offset_lookup
	import lio_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [1:0]        mode,
	input  wire logic [7:0]        byte_value,
	input  wire logic [OffW-1:0]   query_offset,
	input  wire logic [11:0]       query_line,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   found,
	output logic [CntW-1:0]        line_number,
	output logic [PosW-1:0]        column_number,
	output logic [OffW-1:0]        line_start,
	output logic [OffW-1:0]        line_len,
	output logic                   index_overflow
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHK,
		ST_CMP,
		ST_LRD0,
		ST_LRD1,
		ST_LFIN,
		ST_PUSH
	} state_t;

	typedef enum logic [1:0] {
		RES_MISS,
		RES_OFFSET,
		RES_LINE
	} kind_t;

	state_t          state_q;
	kind_t           kind_q;
	logic [CntW-1:0] line_total_q;
	logic [PosW-1:0] bytes_seen_q;
	logic            last_was_cr_q;
	logic            ovf_q;
	logic [CntW-1:0] lo_q;
	logic [CntW-1:0] hi_q;
	logic [AddrW-1:0] mid_q;
	logic [AddrW-1:0] idx_q;
	logic [PosW-1:0] st_q;
	logic [OffW-1:0] off_q;
	logic [CntW-1:0] ln_q;
	logic [OffW-1:0] len_q;
	logic            out_valid_q;
	logic            found_q;
	logic [CntW-1:0] line_number_q;
	logic [PosW-1:0] column_q;
	logic [OffW-1:0] line_start_q;
	logic [OffW-1:0] line_len_q;
	logic            overflow_q;

	// entry k holds {CR before the LF ending line k-1, start of line k}
	logic [PosW:0]   line_mem_q [MaxLines];
	logic [PosW:0]   rd_data_q;
	logic [AddrW-1:0] rd_addr;
	logic            mem_we;
	logic [PosW-1:0] bytes_next;

	logic [CntW:0]   mid_sum;
	logic [CntW-1:0] mid;
	logic [PosW-1:0] rd_start;
	logic [PosW-1:0] cand_st;
	logic            next_in_table;
	logic [PosW-1:0] nst_less;
	logic [PosW-1:0] end_val;
	logic [PosW-1:0] sat_in;
	logic [OffW-1:0] sat_st;
	logic            take;
	sub_req_t        sub_req;
	sub_rsp_t        sub_rsp;

	lio_sub u_sub (
		.req (sub_req),
		.rsp (sub_rsp)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;

	always_comb begin
		mid_sum       = {1'b0, lo_q} + {1'b0, hi_q};
		mid           = mid_sum[CntW:1];
		rd_start      = rd_data_q[PosW-1:0];
		cand_st       = (mid_q == '0) ? '0 : rd_start;
		next_in_table = ({1'b0, idx_q} + CntW'(1)) < line_total_q;
		nst_less      = rd_start - PosW'(1);
		if (next_in_table) begin
			end_val = (rd_data_q[PosW] && nst_less > st_q) ? nst_less - PosW'(1) : nst_less;
		end else begin
			end_val = (last_was_cr_q && bytes_seen_q > st_q) ?
				bytes_seen_q - PosW'(1) : bytes_seen_q;
		end
		sat_in = st_q;
		sat_st = sat_in[OffW] ? '1 : sat_in[OffW-1:0];
	end

	always_comb begin
		unique case (state_q)
			ST_CMP: begin
				sub_req.a = {1'b0, off_q};
				sub_req.b = cand_st;
			end
			ST_LFIN: begin
				sub_req.a = end_val;
				sub_req.b = st_q;
			end
			default: begin
				sub_req.a = {1'b0, off_q};
				sub_req.b = st_q;
			end
		endcase
	end

	always_comb begin
		unique case (state_q)
			ST_CHK:  rd_addr = mid[AddrW-1:0];
			ST_LRD1: rd_addr = idx_q + AddrW'(1);
			default: rd_addr = idx_q;
		endcase
	end

	assign bytes_next = bytes_seen_q + PosW'(1);
	assign mem_we = take && (mode_t'(mode) == MODE_BYTE) &&
		(bytes_seen_q != PosW'(MaxBytes)) && (byte_value == ChLf) &&
		(line_total_q < CntW'(MaxLines));

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem_q[line_total_q[AddrW-1:0]] <= {last_was_cr_q, bytes_next};
		end
		rd_data_q <= line_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			kind_q        <= RES_MISS;
			line_total_q  <= CntW'(1);
			bytes_seen_q  <= '0;
			last_was_cr_q <= 1'b0;
			ovf_q         <= 1'b0;
			lo_q          <= '0;
			hi_q          <= '0;
			mid_q         <= '0;
			idx_q         <= '0;
			st_q          <= '0;
			off_q         <= '0;
			ln_q          <= '0;
			len_q         <= '0;
			out_valid_q   <= 1'b0;
			found_q       <= 1'b0;
			line_number_q <= '0;
			column_q      <= '0;
			line_start_q  <= '0;
			line_len_q    <= '0;
			overflow_q    <= 1'b0;
		end else begin
			if (out_ready && state_q != ST_PUSH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						unique case (mode_t'(mode))
							MODE_BYTE: begin
								if (bytes_seen_q != PosW'(MaxBytes)) begin
									bytes_seen_q  <= bytes_next;
									last_was_cr_q <= (byte_value == ChCr);
									if (byte_value == ChLf) begin
										if (line_total_q < CntW'(MaxLines)) begin
											line_total_q <= line_total_q + CntW'(1);
										end else begin
											ovf_q <= 1'b1;
										end
									end
								end
							end
							MODE_OFFSET: begin
								off_q   <= query_offset;
								lo_q    <= '0;
								hi_q    <= line_total_q;
								idx_q   <= '0;
								st_q    <= '0;
								kind_q  <= RES_OFFSET;
								state_q <= ST_CHK;
							end
							MODE_LINE: begin
								if (query_line == '0 ||
									query_line > {1'b0, line_total_q}) begin
									kind_q  <= RES_MISS;
									state_q <= ST_PUSH;
								end else begin
									idx_q   <= AddrW'(query_line - 12'd1);
									ln_q    <= query_line[CntW-1:0];
									kind_q  <= RES_LINE;
									state_q <= ST_LRD0;
								end
							end
							MODE_CLEAR: begin
								line_total_q  <= CntW'(1);
								bytes_seen_q  <= '0;
								last_was_cr_q <= 1'b0;
								ovf_q         <= 1'b0;
							end
						endcase
					end
				end
				ST_CHK: begin
					if (lo_q < hi_q) begin
						mid_q   <= mid[AddrW-1:0];
						state_q <= ST_CMP;
					end else begin
						state_q <= ST_PUSH;
					end
				end
				ST_CMP: begin
					if (!sub_rsp.lt) begin
						idx_q <= mid_q;
						st_q  <= cand_st;
						lo_q  <= {1'b0, mid_q} + CntW'(1);
					end else begin
						hi_q <= {1'b0, mid_q};
					end
					state_q <= ST_CHK;
				end
				ST_LRD0: begin
					state_q <= ST_LRD1;
				end
				ST_LRD1: begin
					st_q    <= (idx_q == '0) ? '0 : rd_start;
					state_q <= ST_LFIN;
				end
				ST_LFIN: begin
					len_q   <= sub_rsp.diff[OffW-1:0];
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						overflow_q  <= ovf_q;
						unique case (kind_q)
							RES_OFFSET: begin
								found_q       <= 1'b1;
								line_number_q <= {1'b0, idx_q} + CntW'(1);
								column_q      <= sub_rsp.diff + PosW'(1);
								line_start_q  <= sat_st;
								line_len_q    <= '0;
							end
							RES_LINE: begin
								found_q       <= 1'b1;
								line_number_q <= ln_q;
								column_q      <= '0;
								line_start_q  <= sat_st;
								line_len_q    <= len_q;
							end
							default: begin
								found_q       <= 1'b0;
								line_number_q <= '0;
								column_q      <= '0;
								line_start_q  <= '0;
								line_len_q    <= '0;
							end
						endcase
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign found          = found_q;
	assign line_number    = line_number_q;
	assign column_number  = column_q;
	assign line_start     = line_start_q;
	assign line_len       = line_len_q;
	assign index_overflow = overflow_q;

`ifndef SYNTH
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		line_total_q >= CntW'(1) && line_total_q <= CntW'(MaxLines))
		else $error("line count out of range");

	a_bytes_range: assert property (@(posedge clk) disable iff (!arst_n)
		bytes_seen_q <= PosW'(MaxBytes))
		else $error("byte count beyond capacity");

	a_ovf_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> $past(take && mode == MODE_BYTE && byte_value == ChLf))
		else $error("overflow set without an LF transfer");

	a_found_line: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && found_q |-> line_number_q != '0 && line_number_q <= CntW'(MaxLines))
		else $error("found result with bad line number");
`endif

endmodule

`default_nettype wire

[tb/tb_line_index_offset_lookup.sv]
`timescale 1ns / 1ps

module tb_line_index_offset_lookup;
	import lio_pkg::*;

	localparam int StallLimit = 2000;
	localparam int HoldCycles = 400;
	localparam int RandItems  = 370;

	typedef struct packed {
		logic            found;
		logic [CntW-1:0] line_number;
		logic [PosW-1:0] column_number;
		logic [OffW-1:0] line_start;
		logic [OffW-1:0] line_len;
		logic            index_overflow;
	} lookup_t;

	class line_index_tracker;
		int unsigned starts[MaxLines];
		bit          ends_cr[MaxLines];
		int unsigned total;
		int unsigned bytes_in;
		bit          last_cr;
		bit          ovf;
		lookup_t     answers_due[$];
		int          mismatches;

		function new();
			mismatches = 0;
			clear_file();
		endfunction

		function void clear_file();
			starts[0]  = 0;
			ends_cr[0] = 1'b0;
			total      = 1;
			bytes_in   = 0;
			last_cr    = 1'b0;
			ovf        = 1'b0;
		endfunction

		function void take_byte(logic [7:0] b);
			if (bytes_in >= MaxBytes)
				return;
			bytes_in++;
			if (b == ChLf) begin
				if (total < MaxLines) begin
					ends_cr[total-1] = last_cr;
					starts[total]    = bytes_in;
					ends_cr[total]   = 1'b0;
					total++;
				end else begin
					ovf = 1'b1;
				end
			end
			last_cr = (b == ChCr);
		endfunction

		// last recorded start not above the offset
		function int unsigned find_line(int unsigned off);
			int unsigned lo, hi, mid, idx;
			lo  = 0;
			hi  = total;
			idx = 0;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (starts[mid] <= off) begin
					idx = mid;
					lo  = mid + 1;
				end else begin
					hi = mid;
				end
			end
			return idx;
		endfunction

		function logic [OffW-1:0] clip_start(int unsigned s);
			return (s > {OffW{1'b1}}) ? {OffW{1'b1}} : s[OffW-1:0];
		endfunction

		function void note_item(mode_t m, logic [7:0] b, logic [OffW-1:0] off,
				logic [11:0] ln);
			lookup_t     r;
			int unsigned idx, st, stop;
			r = '0;
			r.index_overflow = ovf;
			case (m)
			MODE_BYTE: take_byte(b);
			MODE_CLEAR: clear_file();
			MODE_OFFSET: begin
				idx = find_line(off);
				st  = starts[idx];
				r.found         = 1'b1;
				r.line_number   = CntW'(idx + 1);
				r.column_number = PosW'(off - st + 1);
				r.line_start    = clip_start(st);
				answers_due.push_back(r);
			end
			MODE_LINE: begin
				if (ln >= 1 && ln <= total) begin
					idx = ln - 1;
					st  = starts[idx];
					if (idx + 1 < total) begin
						stop = starts[idx+1] - 1;
						if (ends_cr[idx] && stop > st)
							stop--;
					end else begin
						stop = bytes_in;
						if (stop > st && last_cr)
							stop--;
					end
					r.found       = 1'b1;
					r.line_number = CntW'(ln);
					r.line_start  = clip_start(st);
					r.line_len    = OffW'(stop - st);
				end
				answers_due.push_back(r);
			end
			endcase
		endfunction

		function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_answer(lookup_t got);
			lookup_t want;
			if (answers_due.size() == 0) begin
				$error("result transfer with nothing outstanding");
				mismatches++;
				return;
			end
			want = answers_due.pop_front();
			cmp_field("found", want.found, got.found);
			cmp_field("line_number", want.line_number, got.line_number);
			cmp_field("column_number", want.column_number, got.column_number);
			cmp_field("line_start", want.line_start, got.line_start);
			cmp_field("line_len", want.line_len, got.line_len);
			cmp_field("index_overflow", want.index_overflow, got.index_overflow);
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            in_valid;
	logic            in_ready;
	mode_t           mode;
	logic [7:0]      byte_value;
	logic [OffW-1:0] query_offset;
	logic [11:0]     query_line;
	logic            out_valid;
	logic            out_ready;
	logic            found;
	logic [CntW-1:0] line_number;
	logic [PosW-1:0] column_number;
	logic [OffW-1:0] line_start;
	logic [OffW-1:0] line_len;
	logic            index_overflow;

	line_index_tracker sb;
	bit          tx_idle_en = 1'b1;
	bit          rx_idle_en = 1'b1;
	bit          hold_req   = 1'b0;
	int unsigned gen_bytes  = 0;
	int unsigned gen_lines  = 1;
	int          quiet      = 0;

	line_index_offset_lookup dut (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic push_item(mode_t m, logic [7:0] b, logic [OffW-1:0] off, logic [11:0] ln);
		@(negedge clk);
		while (tx_idle_en && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		mode         <= m;
		byte_value   <= b;
		query_offset <= off;
		query_line   <= ln;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic byte_item(logic [7:0] b);
		push_item(MODE_BYTE, b, OffW'($urandom), 12'($urandom));
		if (gen_bytes < MaxBytes) begin
			gen_bytes++;
			if (b == ChLf && gen_lines < MaxLines)
				gen_lines++;
		end
	endtask

	task automatic offset_item(logic [OffW-1:0] off);
		push_item(MODE_OFFSET, 8'($urandom), off, 12'($urandom));
	endtask

	task automatic line_item(logic [11:0] ln);
		push_item(MODE_LINE, 8'($urandom), OffW'($urandom), ln);
	endtask

	task automatic clear_item();
		push_item(MODE_CLEAR, 8'($urandom), OffW'($urandom), 12'($urandom));
		gen_bytes = 0;
		gen_lines = 1;
	endtask

	// transfer monitor, prediction and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_item(mode, byte_value, query_offset, query_line);
			if (out_valid && out_ready)
				sb.check_answer({found, line_number, column_number, line_start,
					line_len, index_overflow});
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= StallLimit) begin
				$display("[line_index_offset_lookup] ERROR");
				$finish;
			end
		end
	end

	// result side: random stalls plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= !(rx_idle_en && $urandom_range(99) < 6);
			end
		end
	end

	initial begin
		logic [7:0]  b;
		int unsigned r;
		sb           = new();
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		mode         = MODE_BYTE;
		byte_value   = '0;
		query_offset = '0;
		query_line   = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty file, field extremes, CR/LF endings, clear
		offset_item('0);
		offset_item({OffW{1'b1}});
		line_item(12'd0);
		line_item(12'd1);
		line_item(12'd2);
		line_item(12'hFFF);
		byte_item(8'h61);
		byte_item(ChCr);
		byte_item(ChLf);
		byte_item(ChCr);
		byte_item(ChLf);
		byte_item(ChCr);
		byte_item(8'h62);
		byte_item(ChCr);
		line_item(12'd1);
		line_item(12'd2);
		line_item(12'd3);
		line_item(12'd4);
		offset_item(20'd2);
		offset_item(20'd5);
		offset_item(20'd7);
		offset_item(20'd100);
		byte_item(8'h00);
		byte_item(8'hFF);
		clear_item();
		line_item(12'd2);
		offset_item(20'd3);

		// random text with queries mixed in
		clear_item();
		for (int i = 0; i < RandItems; i++) begin
			if (i == 150)
				hold_req = 1'b1;
			if (i == 230) begin
				tx_idle_en = 1'b0;
				rx_idle_en = 1'b0;
			end
			if (i == 340) begin
				tx_idle_en = 1'b1;
				rx_idle_en = 1'b1;
			end
			r = $urandom_range(99);
			if (r < 2) begin
				clear_item();
			end else if (r < 57) begin
				r = $urandom_range(99);
				if (r < 18)
					b = ChLf;
				else if (r < 28)
					b = ChCr;
				else
					b = 8'($urandom);
				byte_item(b);
			end else if (r < 78) begin
				if ($urandom_range(9) == 0)
					offset_item(OffW'($urandom));
				else
					offset_item(OffW'($urandom_range(gen_bytes + 2)));
			end else begin
				r = $urandom_range(9);
				if (r == 0)
					line_item(12'($urandom));
				else if (r == 1)
					line_item(12'(gen_lines + 1));
				else if (r == 2)
					line_item(12'd0);
				else
					line_item(12'($urandom_range(gen_lines, 1)));
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.answers_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.mismatches == 0 && sb.answers_due.size() == 0)
			$display("[line_index_offset_lookup] OK");
		else
			$display("[line_index_offset_lookup] ERROR");
		$finish;
	end

endmodule
